// ===== sv/sbfr_pkg.sv =====
`default_nettype none
package sbfr_pkg;

    localparam logic [7:0] END_MARK   = 8'h0f;
    localparam logic [3:0] TYPE_REQ_A = 4'd1;
    localparam logic [3:0] TYPE_REQ_B = 4'd5;

    // reply select: 0 -> type 8 frame, 1 -> type 9 frame
    localparam logic SEL_T8 = 1'b0;
    localparam logic SEL_T9 = 1'b1;

    localparam int  QDEPTH = 4;
    localparam int  QAW    = $clog2(QDEPTH);

    typedef logic [3:0] t_fidx;

    typedef struct packed {
        logic valid;
        logic sel;
    } t_req;

    localparam t_fidx LAST_T8 = 4'd8;
    localparam t_fidx LAST_T9 = 4'd9;

    function automatic t_fidx frame_last(input logic sel);
        return (sel == SEL_T9) ? LAST_T9 : LAST_T8;
    endfunction

    // header, payload, check byte, terminator
    function automatic logic [7:0] frame_byte(input logic sel, input t_fidx idx);
        logic [7:0] b;
        b = END_MARK;
        if (sel == SEL_T8) begin
            case (idx)
                4'd0:    b = 8'h58;
                4'd1:    b = 8'hc0;
                4'd2:    b = 8'hc0;
                4'd3:    b = 8'hff;
                4'd4:    b = 8'hc0;
                4'd5:    b = 8'h84;
                4'd6:    b = 8'h80;
                4'd7:    b = 8'he4;
                default: b = END_MARK;
            endcase
        end else begin
            case (idx)
                4'd0:    b = 8'h69;
                4'd1:    b = 8'h8a;
                4'd2:    b = 8'h89;
                4'd3:    b = 8'hde;
                4'd4:    b = 8'had;
                4'd5:    b = 8'hc5;
                4'd6:    b = 8'ha5;
                4'd7:    b = 8'h82;
                4'd8:    b = 8'h8c;
                default: b = END_MARK;
            endcase
        end
        return b;
    endfunction

endpackage
`default_nettype wire

// ===== sv/serial_bus_frame_responder_top.sv =====
// Bus frame responder.
// Input channel: one received bus byte per request on i_rx_byte, taken when
// i_push is high and o_full is low. A message ends with byte 0x0f; the low
// nibble of its first byte is the message type.
// Output channel: reply bytes on o_tx_byte / o_last_byte while o_empty is
// low, taken when i_pop is high. o_last_byte marks the closing 0x0f.
// A type 1 message is answered with a 9-byte type 8 frame, a type 5 message
// with a 10-byte type 9 frame; other types get nothing.
// Input bytes are taken one per cycle while o_full is low; o_full rises only
// when four replies are queued and not yet started. The first reply byte
// shows after the queue, frame sequencer and output register; a frame then
// streams one byte per cycle while i_pop is high, with o_empty high between
// back-to-back frames while the sequencer fetches the next queued reply.
// When the receiver holds i_pop low the current byte stays on the ports and
// the queue backs up, eventually raising o_full.
// Synchronous reset (i_rst_n low) drops queued replies and any partial
// message; o_empty is high and o_full low after reset.
`default_nettype none
module serial_bus_frame_responder_top import sbfr_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    output logic            o_full,
    input  wire logic [7:0] i_rx_byte,
    input  wire logic       i_pop,
    output logic            o_empty,
    output logic [7:0]      o_tx_byte,
    output logic            o_last_byte
);

    t_req req;
    logic q_empty, q_sel, q_rd;
    logic accept;

    assign accept = i_push && !o_full;

    sbfr_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_rx_byte (i_rx_byte),
        .o_req     (req)
    );

    sbfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .i_rd    (q_rd),
        .o_full  (o_full),
        .o_empty (q_empty),
        .o_sel   (q_sel)
    );

    sbfr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_sel     (q_sel),
        .o_q_rd      (q_rd),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_tx_byte   (o_tx_byte),
        .o_last_byte (o_last_byte)
    );

endmodule
`default_nettype wire

// ===== sv/sbfr_front.sv =====
`default_nettype none
module sbfr_front import sbfr_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_rx_byte,
    output t_req            o_req
);

    logic       r_within, n_within;
    logic [3:0] r_type, n_type;
    logic [3:0] cur_type;
    logic       is_end;

    assign cur_type = r_within ? r_type : i_rx_byte[3:0];
    assign is_end   = (i_rx_byte == END_MARK);

    always_comb begin
        n_within = r_within;
        n_type   = r_type;
        if (i_accept) begin
            n_type   = cur_type;
            n_within = !is_end;
        end
    end

    always_comb begin
        o_req.valid = i_accept && is_end &&
                      (cur_type == TYPE_REQ_A || cur_type == TYPE_REQ_B);
        o_req.sel   = (cur_type == TYPE_REQ_B) ? SEL_T9 : SEL_T8;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_within <= 1'b0;
            r_type   <= 4'd0;
        end else begin
            r_within <= n_within;
            r_type   <= n_type;
        end
    end

endmodule
`default_nettype wire

// ===== sv/sbfr_queue.sv =====
`default_nettype none
module sbfr_queue import sbfr_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  t_req      i_req,
    input  wire logic i_rd,
    output logic      o_full,
    output logic      o_empty,
    output logic      o_sel
);

    logic [QDEPTH-1:0] r_mem;
    logic [QAW-1:0]    r_wp, r_rp;
    logic [QAW:0]      r_cnt, n_cnt;
    logic              do_wr, do_rd;

    assign o_full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_sel   = r_mem[r_rp];
    assign do_wr   = i_req.valid && !o_full;
    assign do_rd   = i_rd && !o_empty;

    always_comb begin
        n_cnt = r_cnt;
        if (do_wr && !do_rd) n_cnt = r_cnt + 1'b1;
        if (!do_wr && do_rd) n_cnt = r_cnt - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) r_mem[r_wp] <= i_req.sel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_wr) r_wp <= r_wp + 1'b1;
            if (do_rd) r_rp <= r_rp + 1'b1;
            r_cnt <= n_cnt;
        end
    end

endmodule
`default_nettype wire

// ===== sv/sbfr_back.sv =====
`default_nettype none
module sbfr_back import sbfr_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_q_empty,
    input  wire logic       i_q_sel,
    output logic            o_q_rd,
    input  wire logic       i_pop,
    output logic            o_empty,
    output logic [7:0]      o_tx_byte,
    output logic            o_last_byte
);

    logic       r_busy, r_sel;
    t_fidx      r_idx;
    logic       r_ovld;
    logic [7:0] r_tx;
    logic       r_last;
    logic       load, at_end;

    assign o_q_rd = !r_busy && !i_q_empty;
    // while busy, output register takes a new byte when empty or draining this cycle
    assign load   = r_busy && (!r_ovld || i_pop);
    assign at_end = (r_idx == frame_last(r_sel));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ovld <= 1'b0;
        end else begin
            if (o_q_rd) begin
                r_busy <= 1'b1;
            end else if (load && at_end) begin
                r_busy <= 1'b0;
            end
            if (load) begin
                r_ovld <= 1'b1;
            end else if (i_pop) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_rd) begin
            r_sel <= i_q_sel;
            r_idx <= '0;
        end else if (load) begin
            r_idx <= r_idx + 1'b1;
        end
        if (load) begin
            r_tx   <= frame_byte(r_sel, r_idx);
            r_last <= at_end;
        end
    end

    assign o_empty     = !r_ovld;
    assign o_tx_byte   = r_tx;
    assign o_last_byte = r_last;

endmodule
`default_nettype wire

// ===== sv/sbfr_checker.sv =====
`default_nettype none
module sbfr_checker import sbfr_pkg::*; (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_full,
    input wire logic       i_pop,
    input wire logic       o_empty,
    input wire logic [7:0] o_tx_byte,
    input wire logic       o_last_byte
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> o_empty && !o_full)
        else $error("not idle after reset");

    a_last_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_last_byte == (o_tx_byte == END_MARK)))
        else $error("last_byte disagrees with terminator byte");

    a_next_is_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(i_pop && !o_empty && o_last_byte) && !o_empty
        |-> (o_tx_byte == 8'h58 || o_tx_byte == 8'h69))
        else $error("frame does not start with a header");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && !i_pop |=> !o_empty && $stable(o_tx_byte) && $stable(o_last_byte))
        else $error("stalled reply byte changed");

endmodule

bind serial_bus_frame_responder_top sbfr_checker u_sbfr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_full      (o_full),
    .i_pop       (i_pop),
    .o_empty     (o_empty),
    .o_tx_byte   (o_tx_byte),
    .o_last_byte (o_last_byte)
);
`default_nettype wire

// ===== tb/sv/tb_serial_bus_frame_responder_top.sv =====
`default_nettype none
module tb_serial_bus_frame_responder_top;
    import sbfr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 1000;
    localparam int DRAIN_CYCLES = 20;

    localparam logic [3:0] KIND_REPLY_A = 4'd8;
    localparam logic [3:0] KIND_REPLY_B = 4'd9;
    localparam int BODY_LEN_A = 6;
    localparam int BODY_LEN_B = 7;

    typedef struct {
        logic [7:0] tx;
        logic       last;
    } t_reply_byte;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_push = 1'b0;
    logic [7:0] i_rx_byte = 8'h00;
    logic       i_pop = 1'b0;
    logic       o_full;
    logic       o_empty;
    logic [7:0] o_tx_byte;
    logic       o_last_byte;

    t_reply_byte reply_bytes_due[$];
    logic [3:0]  cur_msg_type = 4'd0;
    logic        in_message = 1'b0;

    int  error_count = 0;
    int  bytes_sent = 0;
    int  idle_cycles = 0;
    bit  watchdog_on = 1'b1;
    bit  sender_steady = 1'b0;
    bit  receiver_steady = 1'b0;

    serial_bus_frame_responder_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .o_full      (o_full),
        .i_rx_byte   (i_rx_byte),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_tx_byte   (o_tx_byte),
        .o_last_byte (o_last_byte)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $realtime, what);
        error_count++;
    endtask

    // reply payloads
    function automatic logic [7:0] body_byte(input bit reply_b, input int k);
        logic [7:0] v;
        v = 8'h00;
        if (!reply_b) begin
            case (k)
                0: v = 8'hc0;
                1: v = 8'hc0;
                2: v = 8'hff;
                3: v = 8'hc0;
                4: v = 8'h84;
                default: v = 8'h80;
            endcase
        end else begin
            case (k)
                0: v = 8'h8a;
                1: v = 8'h89;
                2: v = 8'hde;
                3: v = 8'had;
                4: v = 8'hc5;
                5: v = 8'ha5;
                default: v = 8'h82;
            endcase
        end
        return v;
    endfunction

    task automatic queue_reply(input logic [3:0] kind, input bit reply_b, input int len);
        logic [7:0]  header;
        logic [7:0]  p;
        logic [6:0]  sum7;
        t_reply_byte rb;
        header = 8'(kind) + 8'((len - 1) << 4);
        sum7 = header[6:0];
        rb.tx = header;
        rb.last = 1'b0;
        reply_bytes_due.push_back(rb);
        for (int k = 0; k < len; k++) begin
            p = body_byte(reply_b, k);
            sum7 = sum7 + p[6:0];
            rb.tx = p;
            reply_bytes_due.push_back(rb);
        end
        rb.tx = 8'hff - {1'b0, sum7};
        reply_bytes_due.push_back(rb);
        rb.tx = END_MARK;
        rb.last = 1'b1;
        reply_bytes_due.push_back(rb);
    endtask

    task automatic predict_reply(input logic [7:0] b);
        if (!in_message) begin
            cur_msg_type = b[3:0];
            in_message = 1'b1;
        end
        if (b == END_MARK) begin
            in_message = 1'b0;
            if (cur_msg_type == TYPE_REQ_A)
                queue_reply(KIND_REPLY_A, 1'b0, BODY_LEN_A);
            else if (cur_msg_type == TYPE_REQ_B)
                queue_reply(KIND_REPLY_B, 1'b1, BODY_LEN_B);
        end
    endtask

    // one request on the input side; push stays high into the next call
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = sender_steady ? 0 : $urandom_range(0, 10);
        repeat (gap) begin
            i_push <= 1'b0;
            @(posedge i_clk);
        end
        i_push <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_full !== 1'b0);
        predict_reply(b);
        bytes_sent++;
    endtask

    // receiver side
    initial begin
        int stall;
        forever begin
            stall = receiver_steady ? 0 : $urandom_range(0, 10);
            repeat (stall) begin
                i_pop <= 1'b0;
                @(posedge i_clk);
            end
            i_pop <= 1'b1;
            do @(posedge i_clk); while (!i_rst_n || o_empty !== 1'b0);
        end
    end

    always @(posedge i_clk) begin
        t_reply_byte want;
        if (i_rst_n && i_pop && o_empty === 1'b0) begin
            if (reply_bytes_due.size() == 0) begin
                report_mismatch($sformatf("unexpected reply byte %02h last=%b",
                                          o_tx_byte, o_last_byte));
            end else begin
                want = reply_bytes_due.pop_front();
                if (o_tx_byte !== want.tx)
                    report_mismatch($sformatf("tx_byte %02h, want %02h",
                                              o_tx_byte, want.tx));
                if (o_last_byte !== want.last)
                    report_mismatch($sformatf("last_byte %b, want %b (tx %02h)",
                                              o_last_byte, want.last, want.tx));
            end
        end
    end

    always @(posedge i_clk) begin
        if (watchdog_on) begin
            if ((i_push && o_full === 1'b0) || (i_pop && o_empty === 1'b0))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("tb_serial_bus_frame_responder_top: errors");
                $finish;
            end
        end
    end

    function automatic logic [7:0] body_noise();
        logic [7:0] b;
        do b = 8'($urandom); while (b == END_MARK);
        return b;
    endfunction

    task automatic send_message(input logic [7:0] first, input int body_len);
        send_byte(first);
        if (first != END_MARK) begin
            repeat (body_len) send_byte(body_noise());
            send_byte(END_MARK);
        end
    endtask

    // mostly well-formed messages biased to the answered types, some noise
    task automatic run_traffic(input int budget);
        int         pick;
        int         len;
        logic [7:0] first;
        int         stop_at;
        stop_at = bytes_sent + budget;
        while (bytes_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                send_byte(($urandom_range(0, 3) == 0) ? END_MARK : 8'($urandom));
            end else begin
                first = 8'($urandom);
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: first[3:0] = TYPE_REQ_A;
                    4, 5, 6, 7: first[3:0] = TYPE_REQ_B;
                    default: ;
                endcase
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 20)
                                                  : $urandom_range(0, 4);
                send_message(first, len);
            end
        end
    endtask

    task automatic test_answered_types();
        send_message(8'h01, 0);
        send_message(8'hf5, 2);
        send_message(8'h51, 1);
    endtask

    task automatic test_unanswered_types();
        send_byte(END_MARK);            // lone terminator, type 15
        send_message(8'h00, 0);
        send_message(8'hfe, 1);
        send_message(8'h8a, 0);
    endtask

    task automatic test_long_message();
        send_byte(8'ha1);
        send_byte(8'h05);               // not a new first byte
        send_byte(8'hff);
        send_byte(8'h00);
        send_byte(8'h1f);
        send_byte(8'hf0);
        send_byte(END_MARK);
        send_message(8'h05, 0);
    endtask

    task automatic test_random_idle();
        sender_steady = 1'b0;
        receiver_steady = 1'b0;
        run_traffic(250);
    endtask

    task automatic test_random_no_idle();
        sender_steady = 1'b1;
        receiver_steady = 1'b1;
        run_traffic(100);
    endtask

    // steady input with a stalling receiver backs up the reply queue
    task automatic test_random_backpressure();
        sender_steady = 1'b1;
        receiver_steady = 1'b0;
        run_traffic(150);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_answered_types();
        test_unanswered_types();
        test_long_message();
        test_random_idle();
        test_random_no_idle();
        test_random_backpressure();

        i_push <= 1'b0;
        receiver_steady = 1'b0;
        while (reply_bytes_due.size() != 0) @(posedge i_clk);
        watchdog_on = 1'b0;
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("tb_serial_bus_frame_responder_top: clean");
        else
            $display("tb_serial_bus_frame_responder_top: errors");
        $finish;
    end

endmodule
`default_nettype wire

// ===== sim.f =====
sv/sbfr_pkg.sv
sv/sbfr_front.sv
sv/sbfr_queue.sv
sv/sbfr_back.sv
sv/serial_bus_frame_responder_top.sv
sv/sbfr_checker.sv
tb/sv/tb_serial_bus_frame_responder_top.sv
